FILE: design/tccw_pkg.sv
// Shared types and constants of the text console character writer.
package tccw_pkg;

   // Command codes carried on req_tuser
   localparam logic [2:0] CMD_PUT       = 3'd0;
   localparam logic [2:0] CMD_PUT_COLOR = 3'd1;
   localparam logic [2:0] CMD_NEWLINE   = 3'd2;
   localparam logic [2:0] CMD_BACKSPACE = 3'd3;
   localparam logic [2:0] CMD_CLEAR     = 3'd4;
   localparam logic [2:0] CMD_FILL      = 3'd5;
   localparam logic [2:0] CMD_READ      = 3'd6;

   // Special character bytes and the colour a cleared cell takes
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CLEAR_COLOR  = 8'h0F;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SETUP,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Cell operation applied by the walk engine
   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUT,
      OP_PUTC,
      OP_BS,
      OP_SCROLL,
      OP_CLEAR,
      OP_FILL,
      OP_READ
   } op_type;

endpackage

FILE: design/tccw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry each cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/text_console_character_writer_top.sv
// Text console character writer: cell store, cursor and command sequencer.
//
// Commands arrive on the req_ channel (command code on req_tuser, operands on
// req_tdata); every command returns exactly one item on the rsp_ channel with
// the cursor after the command and, for a read, the cell contents.
// The block takes one command at a time: req_tready is high only while the
// sequencer is idle. All cell work goes through one walk engine that reads a
// cell of the screen memory and writes it back in the following cycle, one cell per
// cycle over the single memory read and write port pair.
// A taken command passes through decode and setup; commands that touch no cell
// (newline without scroll, read outside the screen, unused code) then go straight
// to the result, while put, backspace and read walk one cell and scroll, clear and
// fill colour walk every cell, followed by a drain step, before the result. The next
// command can be taken in the same cycle as the result appears.
// After reset the block clears the whole screen (character 0, colour 0x0F)
// with req_tready low until it is done.
// A finished result waits in the output register; the next command is
// accepted meanwhile, and the sequencer only stops when a second result is
// ready while the first has not been taken.
module text_console_character_writer_top #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] char_code, [15:8] color, [20:16] read_row, [27:21] read_col, [31:28] zero
   input  logic [31:0] req_tdata,
   // [2:0] cmd
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [6:0] cursor_col, [11:7] cursor_row, [19:12] cell_char, [27:20] cell_color,
   // [31:28] zero
   output logic [31:0] rsp_tdata
);
   import tccw_pkg::*;

   localparam int CELLS = COLS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(ROWS);
   localparam logic [AW-1:0] COLS_A    = AW'(COLS);
   localparam logic [AW-1:0] TAIL_A    = AW'(CELLS - COLS);
   localparam logic [AW-1:0] LAST_A    = AW'(CELLS - 1);
   localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);
   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

   state_type     st_ff, st_in;
   op_type        op_ff, op_in;
   logic [AW-1:0] walk_ff, walk_in;
   logic [AW-1:0] walk_end_ff, walk_end_in;
   logic          item_ff, item_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic          wr_tail_ff, wr_tail_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_data_ff, rsp_data_in;

   // Command payload
   logic [2:0]    cmd_ff;
   logic [7:0]    ch_ff;
   logic [7:0]    color_ff;
   logic [4:0]    rrow_ff;
   logic [6:0]    rcol_ff;
   logic [15:0]   cell_ff, cell_in;

   logic          req_accept;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rd_data;
   logic [15:0]   wr_data;
   logic [AW-1:0] cur_addr;
   logic [AW-1:0] read_addr;
   logic          read_ok;

   assign req_tready = (st_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Cell addresses of the cursor and of the requested read
   assign cur_addr  = AW'(cur_row_ff) * COLS_A + AW'(cur_col_ff);
   assign read_addr = AW'(rrow_ff) * COLS_A + AW'(rcol_ff);
   assign read_ok   = (int'(rrow_ff) < ROWS) && (int'(rcol_ff) < COLS);

   // Source cell of the walk: scroll pulls from one row below
   assign rd_addr = (op_ff == OP_SCROLL && walk_ff < TAIL_A) ? walk_ff + COLS_A : walk_ff;

   // Build the written cell from the cell read in the previous cycle
   always_comb begin
      unique case (op_ff)
         OP_PUT:    wr_data = {rd_data[15:8], ch_ff};
         OP_PUTC:   wr_data = {color_ff, ch_ff};
         OP_BS:     wr_data = {rd_data[15:8], 8'h00};
         OP_SCROLL: wr_data = wr_tail_ff ? {rd_data[15:8], 8'h00} : rd_data;
         OP_FILL:   wr_data = {color_ff, rd_data[7:0]};
         OP_CLEAR:  wr_data = {CLEAR_COLOR, 8'h00};
         default:   wr_data = rd_data;
      endcase
   end

   tccw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_pend_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: next state, cursor and walk control
   always_comb begin
      logic do_nl;
      logic do_bs;
      st_in        = st_ff;
      op_in        = op_ff;
      walk_in      = walk_ff;
      walk_end_in  = walk_end_ff;
      item_in      = item_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = walk_ff;
      wr_tail_in   = (walk_ff >= TAIL_A);
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      do_nl        = 1'b0;
      do_bs        = 1'b0;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in = 1'b1;
               st_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            op_in = OP_NONE;
            unique case (cmd_ff)
               CMD_PUT: begin
                  if (ch_ff == CH_NEWLINE) begin
                     do_nl = 1'b1;
                  end else if (ch_ff == CH_BACKSPACE) begin
                     do_bs = 1'b1;
                  end else begin
                     op_in = OP_PUT;
                  end
               end
               CMD_PUT_COLOR: begin
                  if (ch_ff == CH_NEWLINE) begin
                     do_nl = 1'b1;
                  end else begin
                     op_in = OP_PUTC;
                  end
               end
               CMD_NEWLINE:   do_nl = 1'b1;
               CMD_BACKSPACE: do_bs = 1'b1;
               CMD_CLEAR: begin
                  op_in      = OP_CLEAR;
                  cur_col_in = '0;
                  cur_row_in = '0;
               end
               CMD_FILL: op_in = OP_FILL;
               CMD_READ: op_in = read_ok ? OP_READ : OP_NONE;
               default:  op_in = OP_NONE;
            endcase
            // Newline: next row, scroll on the last one
            if (do_nl) begin
               cur_col_in = '0;
               if (cur_row_ff == LAST_ROW) begin
                  op_in = OP_SCROLL;
               end else begin
                  cur_row_in = cur_row_ff + 1'b1;
               end
            end
            // Backspace: step back with row wrap, stop at the first cell
            if (do_bs) begin
               op_in = OP_BS;
               if (cur_col_ff != '0) begin
                  cur_col_in = cur_col_ff - 1'b1;
               end else if (cur_row_ff != '0) begin
                  cur_row_in = cur_row_ff - 1'b1;
                  cur_col_in = LAST_COL;
               end
            end
            st_in = ST_SETUP;
         end
         ST_SETUP: begin
            cell_in = '0;
            st_in   = ST_WALK;
            unique case (op_ff)
               OP_PUT, OP_PUTC, OP_BS: begin
                  walk_in     = cur_addr;
                  walk_end_in = cur_addr;
               end
               OP_READ: begin
                  walk_in     = read_addr;
                  walk_end_in = read_addr;
               end
               OP_SCROLL, OP_CLEAR, OP_FILL: begin
                  walk_in     = '0;
                  walk_end_in = LAST_A;
               end
               default: st_in = ST_DONE;
            endcase
            // Advance the cursor past a written character
            if (op_ff == OP_PUT || op_ff == OP_PUTC) begin
               if (cur_col_ff == LAST_COL) begin
                  cur_col_in = '0;
                  if (cur_row_ff != LAST_ROW) begin
                     cur_row_in = cur_row_ff + 1'b1;
                  end
               end else begin
                  cur_col_in = cur_col_ff + 1'b1;
               end
            end
         end
         ST_WALK: begin
            wr_pend_in = (op_ff != OP_READ);
            if (walk_ff == walk_end_ff) begin
               st_in = ST_DRAIN;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (op_ff == OP_READ) begin
               cell_in = rd_data;
            end
            st_in = item_ff ? ST_DONE : ST_IDLE;
         end
         ST_DONE: begin
            // Hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'h0, cell_ff[15:8], cell_ff[7:0],
                               5'(cur_row_ff), 7'(cur_col_ff)};
               st_in        = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // State register; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_WALK;
      end else begin
         st_ff <= st_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_CLEAR;
         walk_ff      <= '0;
         walk_end_ff  <= LAST_A;
         item_ff      <= 1'b0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_ff        <= op_in;
         walk_ff      <= walk_in;
         walk_end_ff  <= walk_end_in;
         item_ff      <= item_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_tuser;
         ch_ff    <= req_tdata[7:0];
         color_ff <= req_tdata[15:8];
         rrow_ff  <= req_tdata[20:16];
         rcol_ff  <= req_tdata[27:21];
      end
      wr_addr_ff  <= wr_addr_in;
      wr_tail_ff  <= wr_tail_in;
      cell_ff     <= cell_in;
      rsp_data_ff <= rsp_data_in;
   end

   // No cell write may still be in flight when a new command is taken
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE) |-> !wr_pend_ff)
      else $error("cell write pending while idle");

   // Cursor stays on the screen
   assert property (@(posedge clock) disable iff (reset)
      (int'(cur_col_ff) < COLS) && (int'(cur_row_ff) < ROWS))
      else $error("cursor off screen");

   // Walk never runs past its last cell
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_WALK) |-> (walk_ff <= walk_end_ff))
      else $error("walk past end");

   // A result is only loaded into a free or draining output register
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DONE && rsp_valid_ff && !rsp_tready) |=> (st_ff == ST_DONE))
      else $error("result overwritten");

endmodule
